// File: rtl/ris_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ris_pkg
// Shared types, constants and compare helpers for the record insertion sorter.
// -----------------------------------------------------------------------------
package ris_pkg;

    localparam int MAX_RECORDS = 16;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int NAME_CHARS  = 19;
    localparam int NAME_W      = 8 * NAME_CHARS;
    localparam int PADDR_W     = 3;

    localparam logic [PADDR_W-1:0] ADDR_SORT_KEY   = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_DESCENDING = 3'd4;

    localparam logic [1:0] KEY_NUMBER = 2'd0;
    localparam logic [1:0] KEY_NAME   = 2'd1;
    localparam logic [1:0] KEY_SCORE  = 2'd2;

    // bit 0: stored entry orders before the new record, bit 1: after it
    localparam logic [1:0] ORD_EQ = 2'b00;
    localparam logic [1:0] ORD_LT = 2'b01;
    localparam logic [1:0] ORD_GT = 2'b10;

    typedef struct packed {
        logic signed [31:0] record_number;
        logic [63:0]        name_bytes_low;
        logic [63:0]        name_bytes_mid;
        logic [23:0]        name_bytes_high;
        logic signed [31:0] score_value;
        logic               is_last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] out_number;
        logic [63:0]        out_name_low;
        logic [63:0]        out_name_mid;
        logic [23:0]        out_name_high;
        logic signed [31:0] out_score;
        logic               out_last;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic signed [31:0] number;
        logic [63:0]        name_low;
        logic [63:0]        name_mid;
        logic [23:0]        name_high;
        logic signed [31:0] score;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_WRITE,
        S_LOAD,
        S_SEND
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan;
        logic shift;
        logic write;
        logic load;
        logic next;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic scan_stop;
        logic shift_done;
        logic rec_last;
        logic emit_last;
    } t_sts;

    function automatic logic [7:0] fold_case(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic [1:0] name_order(logic [NAME_W-1:0] a, logic [NAME_W-1:0] b);
        logic       done;
        logic [7:0] x;
        logic [7:0] y;
        logic [1:0] r;
        done = 1'b0;
        r    = ORD_EQ;
        for (int i = 0; i < NAME_CHARS; i++) begin
            x = fold_case(a[8*i +: 8]);
            y = fold_case(b[8*i +: 8]);
            if (!done) begin
                if (x != y) begin
                    r    = (x < y) ? ORD_LT : ORD_GT;
                    done = 1'b1;
                end else if (x == 8'd0) begin
                    done = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/ris_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ris_ctrl
// Sequencer: capture, scan for the insert point, shift, write, then emit.
// -----------------------------------------------------------------------------
module ris_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_is_last,
    input  logic          i_stall,
    input  ris_pkg::t_sts i_sts,
    output ris_pkg::t_cmd o_cmd,
    output logic          o_stall,
    output logic          o_valid
);
    import ris_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_sts.full) begin
                        n_state = i_is_last ? S_LOAD : S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_stop) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: n_state = i_sts.rec_last ? S_LOAD : S_IDLE;
            S_LOAD:  n_state = S_SEND;
            S_SEND: begin
                if (!i_stall) begin
                    n_state = i_sts.emit_last ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall       = 1'b0;
                o_cmd.capture = i_valid;
            end
            S_SCAN:  o_cmd.scan  = 1'b1;
            S_SHIFT: o_cmd.shift = 1'b1;
            S_WRITE: o_cmd.write = 1'b1;
            S_LOAD:  o_cmd.load  = 1'b1;
            S_SEND: begin
                o_valid    = 1'b1;
                o_cmd.next = !i_stall && !i_sts.emit_last;
                o_cmd.done = !i_stall && i_sts.emit_last;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

// File: rtl/ris_dp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ris_dp
// Record store, key compare, insert shifter and output register.
// -----------------------------------------------------------------------------
module ris_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ris_pkg::t_in  i_in,
    input  logic [1:0]    i_sort_key,
    input  logic          i_descending,
    input  ris_pkg::t_cmd i_cmd,
    output ris_pkg::t_sts o_sts,
    output ris_pkg::t_out o_out
);
    import ris_pkg::*;

    t_rec             r_mem [MAX_RECORDS];
    t_rec             r_new;
    logic             r_last;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_pos;
    logic [CNT_W-1:0] r_fill;
    logic             r_drop;
    t_out             r_out;

    logic [IDX_W-1:0] rd_addr;
    t_rec             rd_rec;
    logic [1:0]       ord;
    logic             hit;
    logic             scan_end;

    assign rd_addr = i_cmd.shift ? IDX_W'(r_idx - CNT_W'(1)) : r_idx[IDX_W-1:0];
    assign rd_rec  = r_mem[rd_addr];

    always_comb begin
        case (i_sort_key)
            KEY_NUMBER: ord = (rd_rec.number < r_new.number) ? ORD_LT :
                              (rd_rec.number > r_new.number) ? ORD_GT : ORD_EQ;
            KEY_SCORE:  ord = (rd_rec.score < r_new.score) ? ORD_LT :
                              (rd_rec.score > r_new.score) ? ORD_GT : ORD_EQ;
            KEY_NAME:   ord = name_order(NAME_W'({rd_rec.name_high, rd_rec.name_mid,
                                                  rd_rec.name_low}),
                                         NAME_W'({r_new.name_high, r_new.name_mid,
                                                  r_new.name_low}));
            default:    ord = ORD_EQ;
        endcase
    end

    // unknown key keeps arrival order: never stop early
    assign hit      = (i_sort_key == KEY_NUMBER || i_sort_key == KEY_NAME ||
                       i_sort_key == KEY_SCORE) &&
                      (i_descending ? ord[0] : ord[1]);
    assign scan_end = (r_idx == r_fill);

    assign o_sts.full       = (r_fill == CNT_W'(MAX_RECORDS));
    assign o_sts.scan_stop  = scan_end || hit;
    assign o_sts.shift_done = (r_idx == r_pos);
    assign o_sts.rec_last   = r_last;
    assign o_sts.emit_last  = r_out.out_last;
    assign o_out            = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift && r_idx != r_pos) begin
            r_mem[r_idx[IDX_W-1:0]] <= rd_rec;
        end
        if (i_cmd.write) begin
            r_mem[r_pos[IDX_W-1:0]] <= r_new;
        end
        if (i_cmd.capture) begin
            r_new.number    <= i_in.record_number;
            r_new.name_low  <= i_in.name_bytes_low;
            r_new.name_mid  <= i_in.name_bytes_mid;
            r_new.name_high <= i_in.name_bytes_high;
            r_new.score     <= i_in.score_value;
            r_last          <= i_in.is_last;
        end
        if (i_cmd.load) begin
            r_out.out_number    <= rd_rec.number;
            r_out.out_name_low  <= rd_rec.name_low;
            r_out.out_name_mid  <= rd_rec.name_mid;
            r_out.out_name_high <= rd_rec.name_high;
            r_out.out_score     <= rd_rec.score;
            r_out.out_last      <= (r_idx == r_fill - CNT_W'(1));
            r_out.overflow      <= r_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pos  <= '0;
            r_fill <= '0;
            r_drop <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_idx <= '0;
                if (o_sts.full) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.scan) begin
                if (o_sts.scan_stop) begin
                    r_pos <= r_idx;
                    r_idx <= r_fill;
                end else begin
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            if (i_cmd.shift && r_idx != r_pos) begin
                r_idx <= r_idx - CNT_W'(1);
            end
            if (i_cmd.write) begin
                r_fill <= r_fill + CNT_W'(1);
                r_idx  <= '0;
            end
            if (i_cmd.next) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (i_cmd.done) begin
                r_fill <= '0;
                r_drop <= 1'b0;
                r_idx  <= '0;
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_RECORDS))
        else $error("fill count beyond capacity");

    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> r_fill == $past(r_fill) + CNT_W'(1))
        else $error("write did not advance fill count");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |=> (r_fill == '0) && !r_drop)
        else $error("store not emptied after run");

    a_load_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (r_fill != '0) && (r_idx < r_fill))
        else $error("emit from empty entry");

endmodule

// File: rtl/record_insertion_sorter_top.sv
`timescale 1ns / 1ps
// Flow: a record is accepted, compared against the stored entries in order up to its insert
// point, the entries from there to the end are shifted up one place, then it is written.
// A full store drops a record and sets overflow. Each result is loaded, then held until taken.
// Throughput: one record at a time; the next is taken when the previous insert ends.
// Reset: synchronous active low; clears control, fill count, overflow and the APB registers.
// -----------------------------------------------------------------------------
// record_insertion_sorter_top
// Stable insertion sort of records with an APB register port.
// -----------------------------------------------------------------------------
module record_insertion_sorter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  ris_pkg::t_in                 i_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output ris_pkg::t_out                o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ris_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import ris_pkg::*;

    logic [1:0] r_sort_key;
    logic       r_descending;
    t_cmd       cmd;
    t_sts       sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_key   <= KEY_NUMBER;
            r_descending <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                ADDR_SORT_KEY:   r_sort_key   <= pwdata[1:0];
                ADDR_DESCENDING: r_descending <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_SORT_KEY:   prdata = {30'd0, r_sort_key};
            ADDR_DESCENDING: prdata = {31'd0, r_descending};
            default:         prdata = '0;
        endcase
    end

    ris_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_is_last (i_in.is_last),
        .i_stall   (i_stall),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_stall   (o_stall),
        .o_valid   (o_valid)
    );

    ris_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_sort_key   (r_sort_key),
        .i_descending (r_descending),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out        (o_out)
    );

endmodule
